// ----- rtl/pem_pkg.sv -----
package pem_pkg;

    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    localparam logic [7:0] EDGE_SAT = 8'd255;

    typedef struct packed {
        logic       action;
        logic [7:0] gray_pixel;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] edge_value;
        logic       frame_last;
    } edge_out_t;

endpackage

// ----- rtl/prewitt_edge_magnitude.sv -----
// Channel   Direction  Handshake              Payload
// s_        in         s_valid / s_ready      pem_pkg::pixel_in_t (action, gray_pixel)
// m_        out        m_valid / m_ready      pem_pkg::edge_out_t (edge_value, frame_last)
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data (frame_width, frame_height)
//
// One transaction at a time: s_ready returns after S_UPD when no result is produced, after
// S_UPD and S_OUT for a border pixel or a flush, and for an interior pixel after S_GRAD,
// S_SQR, S_SUM, the one-bit-per-cycle square root in S_ROOT (skipped when the sum saturates) and S_OUT.
// The line stores are read at the accepting edge and a pixel is written back in S_UPD.
// Reset clears counters and window; line stores are not cleared, so no clearing pass.
// A result waits in the output register; a new result stalls only while it is occupied.
module prewitt_edge_magnitude #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  pem_pkg::pixel_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output pem_pkg::edge_out_t                  m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pem_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pem_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int PW = $clog2(MAX_WIDTH + 2);
    localparam int W_RST = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
    localparam int H_RST = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_UPD  = 7'b0000010,
        S_GRAD = 7'b0000100,
        S_SQR  = 7'b0001000,
        S_SUM  = 7'b0010000,
        S_ROOT = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    function automatic int clamp_dim(input logic [pem_pkg::CFG_DATA_W-1:0] v, input int hi);
        int val;
        val = int'(v);
        if (val < 3) begin
            return 3;
        end
        if (val > hi) begin
            return hi;
        end
        return val;
    endfunction

    state_t              state_reg, state_next;
    logic                act_reg, act_next;
    logic [7:0]          pix_reg, pix_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [RW-1:0]       row_reg, row_next;
    logic [CW-1:0]       res_col_reg, res_col_next;
    logic [RW-1:0]       res_row_reg, res_row_next;
    logic [PW-1:0]       pend_reg, pend_next;
    logic [WW-1:0]       w_eff_reg, w_eff_next;
    logic [HW-1:0]       h_eff_reg, h_eff_next;
    logic [7:0]          win_reg [9];
    logic [7:0]          win_next [9];
    logic signed [10:0]  gv_reg, gv_next;
    logic signed [10:0]  gh_reg, gh_next;
    logic [19:0]         sqa_reg, sqa_next;
    logic [19:0]         sqb_reg, sqb_next;
    logic [20:0]         sum_reg, sum_next;
    logic [7:0]          root_reg, root_next;
    logic [7:0]          bit_reg, bit_next;
    logic [7:0]          val_reg, val_next;
    logic                last_reg, last_next;
    logic                out_valid_reg, out_valid_next;
    pem_pkg::edge_out_t  out_data_reg, out_data_next;

    logic [7:0]          upper_mem [MAX_WIDTH];
    logic [7:0]          middle_mem [MAX_WIDTH];
    logic [7:0]          rd_upper_reg;
    logic [7:0]          rd_middle_reg;
    logic                rd_en;
    logic [CW-1:0]       rd_addr;
    logic                wr_en;

    logic [PW-1:0]       pend_full;
    logic                is_border;
    logic                is_last;
    logic [9:0]          sum_top, sum_bot, sum_left, sum_right;
    logic signed [21:0]  prod_v, prod_h;
    logic [7:0]          trial;
    logic [15:0]         trial_sq;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    assign rd_en   = s_valid && s_ready;
    assign rd_addr = (s_data.action == pem_pkg::ACT_FLUSH) ? res_col_reg : col_reg;
    assign wr_en   = (state_reg == S_UPD) && (act_reg == pem_pkg::ACT_PIXEL);

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_upper_reg <= upper_mem[rd_addr];
        end
        if (wr_en) begin
            upper_mem[col_reg] <= rd_middle_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_middle_reg <= middle_mem[rd_addr];
        end
        if (wr_en) begin
            middle_mem[col_reg] <= pix_reg;
        end
    end

    assign pend_full = PW'(w_eff_reg) + PW'(1);
    assign is_border = (res_row_reg == '0) || (HW'(res_row_reg) == h_eff_reg - HW'(1)) ||
                       (res_col_reg == '0) || (WW'(res_col_reg) == w_eff_reg - WW'(1));
    assign is_last   = (HW'(res_row_reg) == h_eff_reg - HW'(1)) &&
                       (WW'(res_col_reg) == w_eff_reg - WW'(1));

    assign sum_top   = 10'(win_reg[0]) + 10'(win_reg[1]) + 10'(win_reg[2]);
    assign sum_bot   = 10'(win_reg[6]) + 10'(win_reg[7]) + 10'(win_reg[8]);
    assign sum_left  = 10'(win_reg[0]) + 10'(win_reg[3]) + 10'(win_reg[6]);
    assign sum_right = 10'(win_reg[2]) + 10'(win_reg[5]) + 10'(win_reg[8]);
    assign prod_v    = gv_reg * gv_reg;
    assign prod_h    = gh_reg * gh_reg;
    assign trial     = root_reg | bit_reg;
    assign trial_sq  = trial * trial;

    always_comb begin
        state_next     = state_reg;
        act_next       = act_reg;
        pix_next       = pix_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        res_col_next   = res_col_reg;
        res_row_next   = res_row_reg;
        pend_next      = pend_reg;
        w_eff_next     = w_eff_reg;
        h_eff_next     = h_eff_reg;
        win_next       = win_reg;
        gv_next        = gv_reg;
        gh_next        = gh_reg;
        sqa_next       = sqa_reg;
        sqb_next       = sqb_reg;
        sum_next       = sum_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        val_next       = val_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (rd_en) begin
                    act_next   = s_data.action;
                    pix_next   = s_data.gray_pixel;
                    state_next = S_UPD;
                end
            end
            S_UPD: begin
                state_next = S_IDLE;
                if (act_reg == pem_pkg::ACT_PIXEL) begin
                    for (int r = 0; r < 3; r++) begin
                        win_next[r*3]   = win_reg[r*3+1];
                        win_next[r*3+1] = win_reg[r*3+2];
                    end
                    win_next[2] = rd_upper_reg;
                    win_next[5] = rd_middle_reg;
                    win_next[8] = pix_reg;
                    if (WW'(col_reg) + WW'(1) >= w_eff_reg) begin
                        col_next = '0;
                        if (HW'(row_reg) + HW'(1) >= h_eff_reg) begin
                            row_next = '0;
                        end else begin
                            row_next = row_reg + RW'(1);
                        end
                    end else begin
                        col_next = col_reg + CW'(1);
                    end
                    if (pend_reg == pend_full) begin
                        last_next = is_last;
                        if (is_border) begin
                            val_next   = win_reg[5];
                            state_next = S_OUT;
                        end else begin
                            state_next = S_GRAD;
                        end
                    end else begin
                        pend_next = pend_reg + PW'(1);
                    end
                end else if (pend_reg != '0) begin
                    val_next   = (pend_reg == pend_full) ? rd_upper_reg : rd_middle_reg;
                    last_next  = is_last;
                    pend_next  = pend_reg - PW'(1);
                    state_next = S_OUT;
                end
                if (state_next != S_IDLE) begin
                    if (WW'(res_col_reg) + WW'(1) >= w_eff_reg) begin
                        res_col_next = '0;
                        if (HW'(res_row_reg) + HW'(1) >= h_eff_reg) begin
                            res_row_next = '0;
                        end else begin
                            res_row_next = res_row_reg + RW'(1);
                        end
                    end else begin
                        res_col_next = res_col_reg + CW'(1);
                    end
                end
            end
            S_GRAD: begin
                gv_next    = $signed({1'b0, sum_top}) - $signed({1'b0, sum_bot});
                gh_next    = $signed({1'b0, sum_left}) - $signed({1'b0, sum_right});
                state_next = S_SQR;
            end
            S_SQR: begin
                sqa_next   = prod_v[19:0];
                sqb_next   = prod_h[19:0];
                state_next = S_SUM;
            end
            S_SUM: begin
                sum_next   = {1'b0, sqa_reg} + {1'b0, sqb_reg};
                root_next  = '0;
                bit_next   = 8'h80;
                state_next = S_ROOT;
            end
            S_ROOT: begin
                if (sum_reg[20:16] != '0) begin
                    val_next   = pem_pkg::EDGE_SAT;
                    state_next = S_OUT;
                end else begin
                    if (trial_sq <= sum_reg[15:0]) begin
                        root_next = trial;
                    end
                    bit_next = bit_reg >> 1;
                    if (bit_reg[0]) begin
                        val_next   = root_next;
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next           = 1'b1;
                    out_data_next.edge_value = val_reg;
                    out_data_next.frame_last = last_reg;
                    state_next               = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid && cfg_ready) begin
            unique case (pem_pkg::cfg_reg_t'(cfg_index))
                pem_pkg::REG_FRAME_WIDTH: begin
                    w_eff_next = WW'(clamp_dim(cfg_data, MAX_WIDTH));
                end
                pem_pkg::REG_FRAME_HEIGHT: begin
                    h_eff_next = HW'(clamp_dim(cfg_data, MAX_HEIGHT));
                end
                default: begin
                end
            endcase
            col_next     = '0;
            row_next     = '0;
            res_col_next = '0;
            res_row_next = '0;
            pend_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            res_col_reg   <= '0;
            res_row_reg   <= '0;
            pend_reg      <= '0;
            w_eff_reg     <= WW'(W_RST);
            h_eff_reg     <= HW'(H_RST);
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            res_col_reg   <= res_col_next;
            res_row_reg   <= res_row_next;
            pend_reg      <= pend_next;
            w_eff_reg     <= w_eff_next;
            h_eff_reg     <= h_eff_next;
            out_valid_reg <= out_valid_next;
            win_reg       <= win_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg      <= act_next;
        pix_reg      <= pix_next;
        gv_reg       <= gv_next;
        gh_reg       <= gh_next;
        sqa_reg      <= sqa_next;
        sqb_reg      <= sqb_next;
        sum_reg      <= sum_next;
        root_reg     <= root_next;
        bit_reg      <= bit_next;
        val_reg      <= val_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
    end

    a_pend_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= pend_full)
        else $error("pending count above width plus one");

    a_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (WW'(col_reg) < w_eff_reg) && (WW'(res_col_reg) < w_eff_reg))
        else $error("column position outside frame width");

    a_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (HW'(row_reg) < h_eff_reg) && (HW'(res_row_reg) < h_eff_reg))
        else $error("row position outside frame height");

    a_root_below: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ROOT) |-> ((16'(root_reg) * 16'(root_reg)) <= sum_reg[15:0]) ||
                                  (sum_reg[20:16] != '0))
        else $error("partial root overshoots the sum of squares");

    a_last_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UPD && state_next != S_IDLE && is_last && !cfg_valid) |=>
        (res_col_reg == '0) && (res_row_reg == '0))
        else $error("result position did not wrap after the last pixel");

endmodule

// ----- dv/tb_prewitt_edge_magnitude.sv -----
module tb_prewitt_edge_magnitude;

    localparam int MAX_DIM         = 1024;
    localparam int SETTLE_CYCLES   = 24;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_ITEMS    = 400;

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    pem_pkg::pixel_in_t              s_data;
    logic                            m_valid;
    logic                            m_ready;
    pem_pkg::edge_out_t              m_data;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [pem_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [pem_pkg::CFG_DATA_W-1:0]  cfg_data;

    // predictor state
    bit [7:0]            upper_row [MAX_DIM];
    bit [7:0]            middle_row [MAX_DIM];
    int                  win [9] = '{default: 0};
    int unsigned         in_col = 0;
    int unsigned         pending = 0;
    int unsigned         out_col = 0;
    int unsigned         out_row = 0;
    logic [10:0]         width_reg = 11'd640;
    logic [10:0]         height_reg = 11'd480;
    pem_pkg::edge_out_t  expected_edges [$];

    int unsigned     error_count = 0;
    int unsigned     items_sent = 0;
    int unsigned     pixels_sent = 0;
    int unsigned     flushes_sent = 0;
    int unsigned     edges_checked = 0;
    int unsigned     geometry_writes = 0;
    int unsigned     quiet_cycles = 0;
    bit              steady_stream = 1'b0;
    bit              steady_sink = 1'b0;
    bit              hold_sink = 1'b0;

    prewitt_edge_magnitude #(
        .MAX_WIDTH  (MAX_DIM),
        .MAX_HEIGHT (MAX_DIM)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int unsigned eff_dim(input logic [10:0] v);
        if (v < 11'd3) return 3;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    function automatic logic [7:0] rand_gray();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic queue_edge(input int unsigned value, input int unsigned w,
                              input int unsigned h);
        pem_pkg::edge_out_t res;
        res.edge_value = value[7:0];
        res.frame_last = (out_row == h - 1) && (out_col == w - 1);
        expected_edges.push_back(res);
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
            if (out_row >= h) out_row = 0;
        end
    endtask

    task automatic advance_prewitt(input pem_pkg::pixel_in_t item);
        int unsigned w, h, c, value, sum, root, trial;
        int          gv, gh;
        w = eff_dim(width_reg);
        h = eff_dim(height_reg);
        if (item.action == pem_pkg::ACT_FLUSH) begin
            flushes_sent++;
            if (pending == 0) return;
            value = (pending == w + 1) ? upper_row[out_col] : middle_row[out_col];
            pending--;
            queue_edge(value, w, h);
            return;
        end
        pixels_sent++;
        c = in_col;
        for (int r = 0; r < 3; r++) begin
            win[r * 3]     = win[r * 3 + 1];
            win[r * 3 + 1] = win[r * 3 + 2];
        end
        win[2] = upper_row[c];
        win[5] = middle_row[c];
        win[8] = item.gray_pixel;
        upper_row[c]  = middle_row[c];
        middle_row[c] = item.gray_pixel;
        in_col++;
        if (in_col >= w) in_col = 0;
        pending++;
        if (pending <= w + 1) return;
        pending = w + 1;
        if (out_row == 0 || out_row == h - 1 || out_col == 0 || out_col == w - 1) begin
            value = win[4];
        end else begin
            gv = win[0] + win[1] + win[2] - win[6] - win[7] - win[8];
            gh = win[0] + win[3] + win[6] - win[2] - win[5] - win[8];
            sum = gv * gv + gh * gh;
            if (sum >= 65536) begin
                value = pem_pkg::EDGE_SAT;
            end else begin
                root = 0;
                for (int b = 7; b >= 0; b--) begin
                    trial = root | (1 << b);
                    if (trial * trial <= sum) root = trial;
                end
                value = root;
            end
        end
        queue_edge(value, w, h);
    endtask

    task automatic push_item(input logic act, input logic [7:0] value);
        pem_pkg::pixel_in_t item;
        int unsigned        gap;
        item.action     = act;
        item.gray_pixel = value;
        gap = steady_stream ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        advance_prewitt(item);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_edges.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_geometry(input pem_pkg::cfg_reg_t idx, input logic [10:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        geometry_writes++;
        if (idx == pem_pkg::REG_FRAME_WIDTH) width_reg = value;
        else height_reg = value;
        in_col  = 0;
        pending = 0;
        out_col = 0;
        out_row = 0;
    endtask

    task automatic flush_pending(input int unsigned extra);
        int unsigned n;
        n = pending + extra;
        repeat (n) push_item(pem_pkg::ACT_FLUSH, rand_gray());
    endtask

    task automatic test_reset_geometry();
        repeat (3) push_item(pem_pkg::ACT_PIXEL, rand_gray());
        flush_pending(1);
    endtask

    task automatic test_small_frames();
        logic [7:0] ramp [18] = '{8'd255, 8'd255, 8'd255, 8'd170, 8'd0, 8'd85,
                                  8'd0, 8'd1, 8'd128, 8'd10, 8'd20, 8'd30,
                                  8'd40, 8'd50, 8'd60, 8'd70, 8'd80, 8'd90};
        write_geometry(pem_pkg::REG_FRAME_WIDTH, 11'd0);
        write_geometry(pem_pkg::REG_FRAME_HEIGHT, 11'd2);
        foreach (ramp[i]) push_item(pem_pkg::ACT_PIXEL, ramp[i]);
        flush_pending(0);
    endtask

    task automatic test_widest_line();
        write_geometry(pem_pkg::REG_FRAME_WIDTH, 11'd2047);
        write_geometry(pem_pkg::REG_FRAME_HEIGHT, 11'd0);
        steady_stream = 1'b1;
        repeat (MAX_DIM + 6) push_item(pem_pkg::ACT_PIXEL, rand_gray());
        steady_stream = 1'b0;
        repeat (4) push_item(pem_pkg::ACT_FLUSH, rand_gray());
        write_geometry(pem_pkg::REG_FRAME_WIDTH, 11'd1024);
        write_geometry(pem_pkg::REG_FRAME_HEIGHT, 11'd1024);
        repeat (20) push_item(pem_pkg::ACT_PIXEL, rand_gray());
        flush_pending(1);
    endtask

    task automatic test_output_backpressure();
        write_geometry(pem_pkg::REG_FRAME_WIDTH, 11'd5);
        write_geometry(pem_pkg::REG_FRAME_HEIGHT, 11'd4);
        hold_sink     = 1'b1;
        steady_stream = 1'b1;
        repeat (60) push_item(pem_pkg::ACT_PIXEL, rand_gray());
        steady_stream = 1'b0;
        flush_pending(0);
        drain_results();
    endtask

    task automatic test_random_geometry();
        int unsigned start, w, h, cut, n;
        logic [10:0] wv, hv;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       wv = 11'($urandom_range(0, 2));
                1:       wv = 11'($urandom_range(1024, 2047));
                default: wv = 11'($urandom_range(3, 12));
            endcase
            case ($urandom_range(0, 9))
                0:       hv = 11'($urandom_range(0, 2));
                1:       hv = 11'($urandom_range(1024, 2047));
                default: hv = 11'($urandom_range(3, 8));
            endcase
            if ($urandom_range(0, 3) != 0) write_geometry(pem_pkg::REG_FRAME_WIDTH, wv);
            write_geometry(pem_pkg::REG_FRAME_HEIGHT, hv);
            steady_stream = ($urandom_range(0, 3) == 0);
            steady_sink   = ($urandom_range(0, 3) == 0);
            w = eff_dim(width_reg);
            h = eff_dim(height_reg);
            if (w * h > 200) begin
                n = $urandom_range(1, 120);
                repeat (n) begin
                    if ($urandom_range(0, 15) == 0) push_item(pem_pkg::ACT_FLUSH, rand_gray());
                    push_item(pem_pkg::ACT_PIXEL, rand_gray());
                end
                if ($urandom_range(0, 1) != 0) flush_pending($urandom_range(0, 1));
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, w * h - 1) : w * h;
                    repeat (cut) begin
                        if ($urandom_range(0, 15) == 0) begin
                            push_item(pem_pkg::ACT_FLUSH, rand_gray());
                        end
                        push_item(pem_pkg::ACT_PIXEL, rand_gray());
                    end
                    if ($urandom_range(0, 1) != 0) flush_pending($urandom_range(0, 1));
                    if ($urandom_range(0, 7) == 0) drain_results();
                end
            end
        end
        steady_stream = 1'b0;
        steady_sink   = 1'b0;
    endtask

    initial begin : edge_sink
        int unsigned        stall;
        pem_pkg::edge_out_t want;
        m_ready <= 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_sink) begin
                hold_sink = 1'b0;
                stall = HOLD_CYCLES;
            end else begin
                stall = steady_sink ? 0 : $urandom_range(0, 15);
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            edges_checked++;
            if (expected_edges.size() == 0) begin
                $error("unexpected edge result: edge_value %0d frame_last %0b",
                       m_data.edge_value, m_data.frame_last);
                error_count++;
            end else begin
                want = expected_edges.pop_front();
                if (m_data.edge_value !== want.edge_value) begin
                    $error("edge_value mismatch: expected %0d, actual %0d",
                           want.edge_value, m_data.edge_value);
                    error_count++;
                end
                if (m_data.frame_last !== want.frame_last) begin
                    $error("frame_last mismatch: expected %0b, actual %0b",
                           want.frame_last, m_data.frame_last);
                    error_count++;
                end
            end
        end
    end

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= pem_pkg::REG_FRAME_WIDTH;
        cfg_data  <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_geometry();
        test_small_frames();
        test_widest_line();
        test_output_backpressure();
        test_random_geometry();
        drain_results();
        if (expected_edges.size() != 0) begin
            $error("%0d expected edge results never arrived", expected_edges.size());
            error_count++;
        end
        $display("Checked %0d edge results from %0d pixels and %0d flushes.",
                 edges_checked, pixels_sent, flushes_sent);
        $display("Geometry rewritten %0d times, from clamped 3x3 frames to 1024-wide lines.",
                 geometry_writes);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/pem_pkg.sv
rtl/prewitt_edge_magnitude.sv
dv/tb_prewitt_edge_magnitude.sv
